>>> hw/rtl/bst_pkg.sv
// Package: shared constants and result type for the source tokenizer.
package bst_pkg;

  localparam int PosWidth = 16;
  localparam int MaxNest  = 255;
  localparam int NestWidth = 8;

  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_LINE   = 3'd4;
  localparam logic [2:0] M_BLOCK  = 3'd5;

  localparam logic [4:0] K_IDENT   = 5'd0;
  localparam logic [4:0] K_NUMBER  = 5'd8;
  localparam logic [4:0] K_STRING  = 5'd9;
  localparam logic [4:0] K_COMMENT = 5'd10;
  localparam logic [4:0] K_COLON   = 5'd11;
  localparam logic [4:0] K_EQUAL   = 5'd12;
  localparam logic [4:0] K_COMMA   = 5'd13;
  localparam logic [4:0] K_LPAREN  = 5'd14;
  localparam logic [4:0] K_RPAREN  = 5'd15;
  localparam logic [4:0] K_EOL     = 5'd16;
  localparam logic [4:0] K_INVALID = 5'd17;

  typedef struct packed {
    logic [7:0]          bad_char;
    logic [PosWidth-1:0] length;
    logic [PosWidth-1:0] start_col;
    logic [PosWidth-1:0] start_line;
    logic [4:0]          kind;
  } tok_t;

  // Keyword characters, upper case, zero beyond the keyword's length.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
    logic [63:0] s;
    s = 64'd0;
    unique case (k)
      3'd0: s = {40'd0, "MID"};
      3'd1: s = {48'd0, "SA"};
      3'd2: s = {16'd0, "GNIRTS"};
      3'd3: s = {8'd0, "REGETNI"};
      3'd4: s = "NOITCNUF";
      3'd5: s = {8'd0, "ERALCED"};
      3'd6: s = {40'd0, "DNE"};
      default: s = 64'd0;
    endcase
    kw_char = (i < 4'd8) ? s[i[2:0]*8 +: 8] : 8'd0;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    unique case (k)
      3'd0: kw_len = 4'd3;
      3'd1: kw_len = 4'd2;
      3'd2: kw_len = 4'd6;
      3'd3: kw_len = 4'd7;
      3'd4: kw_len = 4'd8;
      3'd5: kw_len = 4'd7;
      3'd6: kw_len = 4'd3;
      default: kw_len = 4'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/basic_source_tokenizer_unit.sv
// Top level: byte-stream tokenizer for a small BASIC-like language.
//
// Input stream s_axis: one word per source byte; tdata = byte_req, tuser = is_end.
// An end word flushes any pending token, adds a final end of line if the line
// holds anything, and returns the scanner to its reset state.
// Output stream m_axis: one word per token. tdata packs kind, start_line,
// start_col, length, bad_char from the lowest bit up; tlast marks the final
// token caused by one input word.
// Each input word yields zero, one or two tokens. The scan state updates in the
// accepting cycle; tokens land in a two-entry output queue and are presented on
// m_axis from its head entry. One input word per cycle is taken while the
// queue can absorb that word's tokens; a word producing two tokens fills the
// queue and holds off the next word until a token drains, limiting the rate.
// When the receiver stalls, the queue holds its words and s_axis_tready drops
// as soon as the free space cannot take two more tokens.
// Reset (rst, synchronous) empties the queue and returns the scanner to the
// start of a source: line and column zero, no token open.
module basic_source_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_req
  input  logic        s_axis_tuser,   // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // kind[4:0], start_line, start_col, length, bad_char, pad
  output logic        m_axis_tlast    // last
);
  import bst_pkg::*;

  // Scanner state.
  logic [2:0]           scan_mode;
  logic [6:0]           keyword_hits;
  logic [3:0]           ident_index;
  logic [NestWidth-1:0] nest_level;
  logic                 pending_quote, pending_slash;
  logic [PosWidth-1:0]  line_count, col_count, tok_line, tok_col, tok_length;
  logic                 has_statement;

  logic [2:0]           scan_mode_next;
  logic [6:0]           keyword_hits_next;
  logic [3:0]           ident_index_next;
  logic [NestWidth-1:0] nest_level_next;
  logic                 pending_quote_next, pending_slash_next;
  logic [PosWidth-1:0]  line_count_next, col_count_next;
  logic [PosWidth-1:0]  tok_line_next, tok_col_next, tok_length_next;
  logic                 has_statement_next;

  // Tokens produced by this word.
  tok_t       tok0, tok1;
  logic [1:0] n_tok;

  // Output queue, two entries.
  tok_t       q_data [2];
  logic       q_last [2];
  logic [1:0] q_count;
  logic       q_rd;

  logic in_fire, out_fire;
  logic [7:0] c;
  logic is_end;

  assign c      = s_axis_tdata;
  assign is_end = s_axis_tuser;

  // Accept only when both possible tokens fit after this cycle's drain.
  assign s_axis_tready = (q_count == 2'd0) || (q_count == 2'd1 && m_axis_tready)
                         || (q_count == 2'd2 && 1'b0);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  function automatic logic [PosWidth-1:0] sat_inc(input logic [PosWidth-1:0] v);
    sat_inc = (v != PosMax) ? v + 1'b1 : v;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = b >= "0" && b <= "9";
  endfunction

  // Keyword tracking for one identifier character at a given index.
  logic [7:0] up;
  logic [6:0] hits_cont, hits_start;
  logic [4:0] ident_kind;

  assign up = (c >= "a" && c <= "z") ? c - 8'd32 : c;

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      hits_cont[k]  = keyword_hits[k] && (ident_index < kw_len(3'(k)))
                      && (kw_char(3'(k), ident_index) == up);
      hits_start[k] = (kw_char(3'(k), 4'd0) == up);
    end
    ident_kind = K_IDENT;
    for (int k = 0; k < 7; k++) begin
      if (keyword_hits[k] && kw_len(3'(k)) == ident_index) ident_kind = 5'(k + 1);
    end
  end

  // Main next-state logic; push appends a token to tok0/tok1.
  always_comb begin
    tok_t t;
    logic do_idle;
    logic block_done;
    scan_mode_next     = scan_mode;
    keyword_hits_next  = keyword_hits;
    ident_index_next   = ident_index;
    nest_level_next    = nest_level;
    pending_quote_next = pending_quote;
    pending_slash_next = pending_slash;
    line_count_next    = line_count;
    col_count_next     = col_count;
    tok_line_next      = tok_line;
    tok_col_next       = tok_col;
    tok_length_next    = tok_length;
    has_statement_next = has_statement;
    tok0  = '0;
    tok1  = '0;
    n_tok = 2'd0;
    t     = '0;
    do_idle = 1'b0;
    block_done = 1'b0;

    t.start_line = tok_line;
    t.start_col  = tok_col;
    t.length     = tok_length;

    if (is_end) begin
      unique case (scan_mode)
        M_IDENT:  begin t.kind = ident_kind; tok0 = t; n_tok = 2'd1; end
        M_NUMBER: begin t.kind = K_NUMBER;   tok0 = t; n_tok = 2'd1; end
        M_STRING: begin t.kind = K_STRING;   tok0 = t; n_tok = 2'd1; end
        M_LINE, M_BLOCK: begin t.kind = K_COMMENT; tok0 = t; n_tok = 2'd1; end
        default: begin
          if (pending_slash) begin
            tok0 = '{bad_char: "/", length: PosWidth'(1), start_col: tok_col,
                     start_line: tok_line, kind: K_INVALID};
            n_tok = 2'd1;
          end
        end
      endcase
      if (has_statement) begin
        t = '{bad_char: 8'd0, length: '0, start_col: col_count,
              start_line: line_count, kind: K_EOL};
        if (n_tok == 2'd0) tok0 = t; else tok1 = t;
        n_tok = n_tok + 2'd1;
      end
      scan_mode_next = M_IDLE;  keyword_hits_next = 7'h7F; ident_index_next = '0;
      nest_level_next = '0;     pending_quote_next = 1'b0; pending_slash_next = 1'b0;
      line_count_next = '0;     col_count_next = '0;       tok_line_next = '0;
      tok_col_next = '0;        tok_length_next = '0;      has_statement_next = 1'b0;
    end else begin
      unique case (scan_mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            tok_length_next   = sat_inc(tok_length);
            keyword_hits_next = hits_cont;
            ident_index_next  = (ident_index != 4'd15) ? ident_index + 4'd1 : ident_index;
          end else begin
            t.kind = ident_kind; tok0 = t; n_tok = 2'd1;
            scan_mode_next = M_IDLE; do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) tok_length_next = sat_inc(tok_length);
          else begin
            t.kind = K_NUMBER; tok0 = t; n_tok = 2'd1;
            scan_mode_next = M_IDLE; do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            t.kind = K_STRING; t.length = sat_inc(tok_length); tok0 = t; n_tok = 2'd1;
            tok_length_next = sat_inc(tok_length);
            scan_mode_next = M_IDLE;
          end else if (c == "\n") begin
            t.kind = K_STRING; tok0 = t; n_tok = 2'd1;
            scan_mode_next = M_IDLE; do_idle = 1'b1;
          end else tok_length_next = sat_inc(tok_length);
        end
        M_LINE: begin
          if (c == "\n") begin
            t.kind = K_COMMENT; tok0 = t; n_tok = 2'd1;
            scan_mode_next = M_IDLE; do_idle = 1'b1;
          end else tok_length_next = sat_inc(tok_length);
        end
        M_BLOCK: begin
          tok_length_next = sat_inc(tok_length);
          if (pending_quote && c == "/") begin
            pending_quote_next = 1'b0;
            block_done = 1'b1;
            if (nest_level <= NestWidth'(1)) begin
              nest_level_next = '0;
              t.kind = K_COMMENT; t.length = sat_inc(tok_length); tok0 = t; n_tok = 2'd1;
              scan_mode_next = M_IDLE;
            end else nest_level_next = nest_level - 1'b1;
          end else if (!pending_quote && pending_slash && c == "'") begin
            pending_slash_next = 1'b0;
            block_done = 1'b1;
            if (nest_level < NestWidth'(MaxNest)) nest_level_next = nest_level + 1'b1;
          end
          if (!block_done) begin
            pending_quote_next = (c == "'");
            pending_slash_next = (c == "/");
          end
        end
        default: begin
          scan_mode_next = M_IDLE;
          if (pending_slash) begin
            pending_slash_next = 1'b0;
            if (c == "'") begin
              tok_length_next = sat_inc(tok_length);
              nest_level_next = NestWidth'(1);
              pending_quote_next = 1'b0;
              scan_mode_next = M_BLOCK;
            end else begin
              tok0 = '{bad_char: "/", length: PosWidth'(1), start_col: tok_col,
                       start_line: tok_line, kind: K_INVALID};
              n_tok = 2'd1;
              do_idle = 1'b1;
            end
          end else do_idle = 1'b1;
        end
      endcase

      // Byte seen between tokens.
      if (do_idle && c != " " && c != "\t") begin
        if (c == "\n") begin
          t = '{bad_char: 8'd0, length: '0, start_col: col_count,
                start_line: line_count, kind: K_EOL};
          has_statement_next = 1'b0;
        end else begin
          has_statement_next = 1'b1;
          tok_line_next   = line_count;
          tok_col_next    = col_count;
          tok_length_next = PosWidth'(1);
          t = '{bad_char: 8'd0, length: PosWidth'(1), start_col: col_count,
                start_line: line_count, kind: K_INVALID};
          if (c == "'") scan_mode_next = M_LINE;
          else if (c == "/") pending_slash_next = 1'b1;
          else if (is_alpha(c) || c == "_") begin
            scan_mode_next    = M_IDENT;
            keyword_hits_next = hits_start;
            ident_index_next  = 4'd1;
          end else if (is_digit(c)) scan_mode_next = M_NUMBER;
          else if (c == "\"") scan_mode_next = M_STRING;
          else if (c == ":") t.kind = K_COLON;
          else if (c == "=") t.kind = K_EQUAL;
          else if (c == ",") t.kind = K_COMMA;
          else if (c == "(") t.kind = K_LPAREN;
          else if (c == ")") t.kind = K_RPAREN;
          else t.bad_char = c;
        end
        if (c == "\n" || !(c == "'" || c == "/" || is_alpha(c) || c == "_"
                           || is_digit(c) || c == "\"")) begin
          if (n_tok == 2'd0) tok0 = t; else tok1 = t;
          n_tok = n_tok + 2'd1;
        end
      end

      if (c == "\n") begin
        line_count_next = sat_inc(line_count);
        col_count_next  = '0;
      end else col_count_next = sat_inc(col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;  keyword_hits <= 7'h7F; ident_index <= '0;
      nest_level <= '0;     pending_quote <= 1'b0; pending_slash <= 1'b0;
      line_count <= '0;     col_count <= '0;       tok_line <= '0;
      tok_col <= '0;        tok_length <= '0;      has_statement <= 1'b0;
    end else if (in_fire) begin
      scan_mode <= scan_mode_next;         keyword_hits <= keyword_hits_next;
      ident_index <= ident_index_next;     nest_level <= nest_level_next;
      pending_quote <= pending_quote_next; pending_slash <= pending_slash_next;
      line_count <= line_count_next;       col_count <= col_count_next;
      tok_line <= tok_line_next;           tok_col <= tok_col_next;
      tok_length <= tok_length_next;       has_statement <= has_statement_next;
    end
  end

  // Output queue: entry 0 is the head. Shift on drain, append behind.
  assign q_rd = out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      q_count <= q_count - {1'b0, q_rd} + (in_fire ? n_tok : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] base;
    base = q_count - {1'b0, q_rd};
    if (q_rd) begin
      q_data[0] <= q_data[1];
      q_last[0] <= q_last[1];
    end
    if (in_fire && n_tok != 2'd0) begin
      if (base == 2'd0) begin
        q_data[0] <= tok0;
        q_last[0] <= (n_tok == 2'd1);
        q_data[1] <= tok1;
        q_last[1] <= 1'b1;
      end else begin
        q_data[1] <= tok0;
        q_last[1] <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = (q_count != 2'd0);
  assign m_axis_tdata  = {3'd0, q_data[0]};
  assign m_axis_tlast  = q_last[0];

  // Queue never overflows.
  assert property (@(posedge clk) disable iff (rst) q_count <= 2'd2)
    else $error("output queue overflow");
  // Two tokens only arrive into an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && n_tok == 2'd2) |-> (q_count - {1'b0, q_rd}) == 2'd0)
    else $error("two tokens into busy queue");
  // An end word leaves the scanner at line zero.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_end) |=> (line_count == '0 && scan_mode == M_IDLE))
    else $error("end word did not reset scanner");
  // Block comment depth is nonzero while inside one.
  assert property (@(posedge clk) disable iff (rst)
    scan_mode == M_BLOCK |-> nest_level != '0)
    else $error("block comment with zero depth");

endmodule
